[src/point_to_scan_min_range_binning_core_assert.svh]
// Assertion macros shared by the scan binning RTL.
// No dependencies; clocked on i_clk, disabled while i_rst_n is low.
`ifndef POINT_TO_SCAN_MIN_RANGE_BINNING_CORE_ASSERT_SVH
`define POINT_TO_SCAN_MIN_RANGE_BINNING_CORE_ASSERT_SVH

// same-cycle implication
`define PSB_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSB_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/psb_pkg.sv]
// Shared constants, codes and the CORDIC arctangent table for the scan binning core.
// No dependencies.
package psb_pkg;

    localparam int BIN_COUNT  = 1024;
    localparam int COORD_BITS = 20;
    localparam int BIN_AW     = $clog2(BIN_COUNT);
    localparam int IDX_W      = 10;
    localparam int RANGE_W    = 20;
    localparam int ANG_W      = 16;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CORDIC_N   = 18;
    localparam int ACC_W      = 22;
    localparam int CORD_W     = 43;
    localparam int SCALE_SH   = 40 - COORD_BITS;
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int ITER_N     = (COORD_BITS > CORDIC_N) ? COORD_BITS : CORDIC_N;
    localparam int CNT_W      = 5;
    localparam int MEM_W      = RANGE_W + 1;

    typedef logic [1:0] t_op;
    localparam t_op OP_CLEAR = 2'd0;
    localparam t_op OP_ADD   = 2'd1;
    localparam t_op OP_READ  = 2'd2;

    typedef logic [2:0] t_verdict;
    localparam t_verdict V_ACCEPT  = 3'd0;
    localparam t_verdict V_INVALID = 3'd1;
    localparam t_verdict V_HEIGHT  = 3'd2;
    localparam t_verdict V_NEAR    = 3'd3;
    localparam t_verdict V_ANGLE   = 3'd4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ANGLE_LOW   = 3'd0;
    localparam t_cfg_idx CFG_ANGLE_HIGH  = 3'd1;
    localparam t_cfg_idx CFG_ANGLE_STEP  = 3'd2;
    localparam t_cfg_idx CFG_NEAR_LIMIT  = 3'd3;
    localparam t_cfg_idx CFG_HEIGHT_LOW  = 3'd4;
    localparam t_cfg_idx CFG_HEIGHT_HIGH = 3'd5;

    // atan(2^-i) in units of 2^20 per turn
    function automatic logic [ACC_W-1:0] atan_lut(input logic [CNT_W-1:0] i);
        logic [ACC_W-1:0] v;
        unique case (i)
            5'd0:    v = 22'd131072;
            5'd1:    v = 22'd77376;
            5'd2:    v = 22'd40884;
            5'd3:    v = 22'd20753;
            5'd4:    v = 22'd10416;
            5'd5:    v = 22'd5213;
            5'd6:    v = 22'd2607;
            5'd7:    v = 22'd1304;
            5'd8:    v = 22'd652;
            5'd9:    v = 22'd326;
            5'd10:   v = 22'd163;
            5'd11:   v = 22'd81;
            5'd12:   v = 22'd41;
            5'd13:   v = 22'd20;
            5'd14:   v = 22'd10;
            5'd15:   v = 22'd5;
            5'd16:   v = 22'd3;
            5'd17:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

[src/psb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module psb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/point_to_scan_min_range_binning_core.sv]
// Top level of the point to scan binning core: sequencer, shared CORDIC /
// square root / divider datapath, config registers. Uses psb_pkg, psb_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one operation word: clear
//   the scan, add a point, or read a bin. Output channel (o_out_valid /
//   i_out_ready) returns one result word per input word, in order.
//   Config writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at once. The core
//   lacks a guard, so the user must make them only while the core is idle.
//   Steps from accept to o_out_valid (o_in_ready rises in the same cycle):
//     add point, rejected : squaring x and y, the shared iterations, check, output
//     add point, accepted : squaring, iterations, check, divider, RAM read, wait, update, output
//     read bin            : RAM read, update, output
//     clear               : one bin per cycle, then output
//   Square root and CORDIC share one iteration counter; the bin number comes
//   from a one-bit-per-cycle restoring divider.
//   Reset: config takes its defaults and a clearing pass over all 1024 bins
//   runs before o_in_ready rises. A stalled receiver holds the result in the
//   output register; the core accepts the next word but does not finish it
//   until the slot frees.
module point_to_scan_min_range_binning_core
    import psb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_op,
    input  logic [COORD_BITS-1:0] i_point_x,
    input  logic [COORD_BITS-1:0] i_point_y,
    input  logic [COORD_BITS-1:0] i_point_z,
    input  logic                  i_point_ok,
    input  logic [IDX_W-1:0]      i_read_bin,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_verdict,
    output logic [IDX_W-1:0]      o_bin_index,
    output logic [RANGE_W-1:0]    o_bin_range,
    output logic                  o_bin_hit
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SQ0, S_SQ1, S_ITER, S_CHECK, S_DIV, S_RD, S_RD_WAIT, S_UPD,
        S_CLR, S_OUT
    } t_state;

    t_state r_state;

    // config
    logic signed [ANG_W-1:0]      r_angle_low, r_angle_high;
    logic [ANG_W-1:0]             r_angle_step;
    logic [RANGE_W-1:0]           r_near_limit;
    logic signed [COORD_BITS-1:0] r_height_low, r_height_high;

    // operands
    t_op                          r_op;
    logic signed [COORD_BITS-1:0] r_x, r_y, r_z;
    logic                         r_ok;
    logic                         r_zero;
    logic [BIN_AW-1:0]            r_bin;
    logic [BIN_AW-1:0]            r_addr;
    logic [CNT_W-1:0]             r_cnt;

    // datapath
    logic [SQ_W-1:0]              r_sqa;
    logic [SQ_W-1:0]              r_v;
    logic [SQ_W-1:0]              r_root;
    logic [SQ_W-1:0]              r_bit;
    logic signed [CORD_W-1:0]     r_cx, r_cy;
    logic signed [ACC_W-1:0]      r_acc;
    logic [RANGE_W-1:0]           r_range;
    logic [ANG_W-1:0]             r_num;
    logic [ANG_W-1:0]             r_den;
    logic [ANG_W:0]               r_rem;

    // staged result and output register
    t_verdict                     r_res_verdict;
    logic [RANGE_W-1:0]           r_res_range;
    logic                         r_res_hit;
    logic                         r_out_valid;
    t_verdict                     r_out_verdict;
    logic [IDX_W-1:0]             r_out_index;
    logic [RANGE_W-1:0]           r_out_range;
    logic                         r_out_hit;

    // memory
    logic                         mem_we;
    logic [BIN_AW-1:0]            mem_waddr;
    logic [MEM_W-1:0]             mem_wdata;
    logic [MEM_W-1:0]             mem_rdata;

    psb_ram #(.WIDTH(MEM_W), .DEPTH(BIN_COUNT)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_bin),
        .o_rdata (mem_rdata)
    );

    // ---------------- combinational datapath ----------------
    logic                         in_fire;
    logic                         out_free;
    logic [COORD_BITS-1:0]        ax, ay, m_op;
    logic [SQ_W-1:0]              m_prod;
    logic signed [CORD_W-1:0]     xs, ys;
    logic [SQ_W:0]                sq_trial;
    logic                         sq_ge;
    logic signed [CORD_W-1:0]     dx, dy;
    logic signed [ACC_W-1:0]      atan_v;
    logic signed [ACC_W-1:0]      acc_rnd;
    logic signed [ANG_W-1:0]      ang;
    logic [RANGE_W-1:0]           root_sat;
    logic signed [ANG_W:0]        ang_off;
    logic [ANG_W:0]               rem2;
    logic                         div_ge;
    logic [BIN_AW-1:0]            quo_bin;
    logic [BIN_AW-1:0]            rd_bin;
    logic                         mem_filled;
    logic [RANGE_W-1:0]           mem_range;
    logic                         take_new;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign ax     = r_x[COORD_BITS-1] ? COORD_BITS'(-r_x) : COORD_BITS'(r_x);
    assign ay     = r_y[COORD_BITS-1] ? COORD_BITS'(-r_y) : COORD_BITS'(r_y);
    // one multiplier, squares x then y
    assign m_op   = (r_state == S_SQ0) ? ax : ay;
    assign m_prod = SQ_W'(m_op) * SQ_W'(m_op);

    assign xs = CORD_W'(r_x) <<< SCALE_SH;
    assign ys = CORD_W'(r_y) <<< SCALE_SH;

    assign sq_trial = {1'b0, r_root} + {1'b0, r_bit};
    assign sq_ge    = {1'b0, r_v} >= sq_trial;

    assign dx     = r_cy >>> r_cnt;
    assign dy     = r_cx >>> r_cnt;
    assign atan_v = signed'(atan_lut(r_cnt));

    assign acc_rnd  = r_acc + ACC_W'(8);
    assign ang      = r_zero ? '0 : signed'(acc_rnd[ANG_W+3:4]);
    assign root_sat = (r_root > SQ_W'((1 << RANGE_W) - 1)) ? '1 : RANGE_W'(r_root);
    assign ang_off  = (ANG_W+1)'(ang) - (ANG_W+1)'(r_angle_low);

    assign rem2   = {r_rem[ANG_W-1:0], r_num[ANG_W-1]};
    assign div_ge = rem2 >= {1'b0, r_den};

    assign quo_bin = (r_num > ANG_W'(BIN_COUNT - 1)) ? BIN_AW'(BIN_COUNT - 1)
                                                     : BIN_AW'(r_num);
    assign rd_bin  = (32'(i_read_bin) > 32'(BIN_COUNT - 1)) ? BIN_AW'(BIN_COUNT - 1)
                                                            : BIN_AW'(i_read_bin);

    assign mem_filled = mem_rdata[MEM_W-1];
    assign mem_range  = mem_rdata[RANGE_W-1:0];
    assign take_new   = !mem_filled || (r_range < mem_range);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        unique case (r_state)
            S_INIT, S_CLR: begin
                mem_we = 1'b1;
            end
            S_UPD: begin
                mem_we    = (r_op == OP_ADD) && take_new;
                mem_waddr = r_bin;
                mem_wdata = {1'b1, r_range};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_out_verdict;
    assign o_bin_index = r_out_index;
    assign o_bin_range = r_out_range;
    assign o_bin_hit   = r_out_hit;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_addr        <= '0;
            r_out_valid   <= 1'b0;
            r_angle_low   <= ANG_W'(-32768);
            r_angle_high  <= ANG_W'(32767);
            r_angle_step  <= ANG_W'(91);
            r_near_limit  <= RANGE_W'(450);
            r_height_low  <= {1'b1, {(COORD_BITS-1){1'b0}}};
            r_height_high <= {1'b0, {(COORD_BITS-1){1'b1}}};
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ANGLE_LOW:   r_angle_low   <= i_cfg_data[ANG_W-1:0];
                    CFG_ANGLE_HIGH:  r_angle_high  <= i_cfg_data[ANG_W-1:0];
                    CFG_ANGLE_STEP:  r_angle_step  <= i_cfg_data[ANG_W-1:0];
                    CFG_NEAR_LIMIT:  r_near_limit  <= i_cfg_data[RANGE_W-1:0];
                    CFG_HEIGHT_LOW:  r_height_low  <= COORD_BITS'(i_cfg_data);
                    CFG_HEIGHT_HIGH: r_height_high <= COORD_BITS'(i_cfg_data);
                    default: ;
                endcase
            end

            // S_OUT reloads the slot itself when it frees
            if (r_out_valid && i_out_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_INIT: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == BIN_AW'(BIN_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_op          <= i_op;
                        r_x           <= i_point_x;
                        r_y           <= i_point_y;
                        r_z           <= i_point_z;
                        r_ok          <= i_point_ok;
                        r_bin         <= rd_bin;
                        r_addr        <= '0;
                        r_res_verdict <= V_ACCEPT;
                        r_res_range   <= '0;
                        r_res_hit     <= 1'b0;
                        unique case (i_op)
                            OP_CLEAR: r_state <= S_CLR;
                            OP_ADD:   r_state <= S_SQ0;
                            OP_READ:  r_state <= S_RD;
                            default:  r_state <= S_OUT;
                        endcase
                    end
                end
                S_SQ0: begin
                    r_sqa  <= m_prod;
                    r_zero <= (r_x == '0) && (r_y == '0);
                    r_root <= '0;
                    r_bit  <= SQ_W'(1) << (SQ_W - 2);
                    r_cnt  <= '0;
                    // pre-rotate the left half plane by a quarter turn
                    if (r_x[COORD_BITS-1]) begin
                        if (!r_y[COORD_BITS-1]) begin
                            r_cx  <= ys;
                            r_cy  <= -xs;
                            r_acc <= ACC_W'(262144);
                        end else begin
                            r_cx  <= -ys;
                            r_cy  <= xs;
                            r_acc <= -ACC_W'(262144);
                        end
                    end else begin
                        r_cx  <= xs;
                        r_cy  <= ys;
                        r_acc <= '0;
                    end
                    r_state <= S_SQ1;
                end
                S_SQ1: begin
                    r_v     <= r_sqa + m_prod;
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    if (32'(r_cnt) < COORD_BITS) begin
                        if (sq_ge) begin
                            r_v    <= r_v - SQ_W'(sq_trial);
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                    if (32'(r_cnt) < CORDIC_N) begin
                        if (!r_cy[CORD_W-1]) begin
                            r_cx  <= r_cx + dx;
                            r_cy  <= r_cy - dy;
                            r_acc <= r_acc + atan_v;
                        end else begin
                            r_cx  <= r_cx - dx;
                            r_cy  <= r_cy + dy;
                            r_acc <= r_acc - atan_v;
                        end
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(ITER_N - 1)) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_range <= root_sat;
                    r_cnt   <= '0;
                    r_num   <= ang_off[ANG_W-1:0];
                    r_den   <= (r_angle_step == '0) ? ANG_W'(1) : r_angle_step;
                    r_rem   <= '0;
                    priority if (!r_ok) begin
                        r_res_verdict <= V_INVALID;
                        r_state       <= S_OUT;
                    end else if (r_z > r_height_high || r_z < r_height_low) begin
                        r_res_verdict <= V_HEIGHT;
                        r_state       <= S_OUT;
                    end else if (root_sat < r_near_limit) begin
                        r_res_verdict <= V_NEAR;
                        r_state       <= S_OUT;
                    end else if (ang < r_angle_low || ang > r_angle_high) begin
                        r_res_verdict <= V_ANGLE;
                        r_state       <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? rem2 - {1'b0, r_den} : rem2;
                    r_num <= {r_num[ANG_W-2:0], div_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(ANG_W - 1)) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_op == OP_ADD) begin
                        r_bin <= quo_bin;
                    end
                    // a new add address waits in S_RD_WAIT until its read data is valid
                    r_state <= (r_op == OP_ADD) ? S_RD_WAIT : S_UPD;
                end
                S_RD_WAIT: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_op == OP_ADD) begin
                        r_res_hit   <= 1'b1;
                        r_res_range <= take_new ? r_range : mem_range;
                    end else begin
                        r_res_hit   <= mem_filled;
                        r_res_range <= mem_filled ? mem_range : '0;
                    end
                    r_state <= S_OUT;
                end
                S_CLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == BIN_AW'(BIN_COUNT - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_verdict <= r_res_verdict;
                        r_out_index   <= (r_res_hit || r_op == OP_READ) ? IDX_W'(r_bin) : '0;
                        r_out_range   <= r_res_range;
                        r_out_hit     <= r_res_hit;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `include "point_to_scan_min_range_binning_core_assert.svh"

    `PSB_ASSERT_IMP(a_hit_only_accept, r_out_valid && r_out_hit,
        r_out_verdict == V_ACCEPT, "bin hit on a rejected word")
    `PSB_ASSERT_IMP(a_reject_zero, r_out_valid && r_out_verdict != V_ACCEPT,
        !r_out_hit && r_out_index == '0 && r_out_range == '0, "rejected word carries data")
    `PSB_ASSERT_IMP(a_index_range, r_out_valid,
        32'(r_out_index) <= BIN_COUNT - 1, "bin index past last bin")
    `PSB_ASSERT_NXT(a_busy_after_accept, in_fire,
        !o_in_ready, "ready again right after accepting a word")
endmodule

[test/point_to_scan_min_range_binning_core_tb.sv]
// Testbench for point_to_scan_min_range_binning_core: directed and random words
// checked against a behavioral scan model with random stalls on both channels.
// Depends on psb_pkg and the core RTL.
`timescale 1ns / 100ps

module point_to_scan_min_range_binning_core_tb;
    import psb_pkg::*;

    localparam t_op OP_UNUSED = 2'd3;
    localparam int  SETTLE    = 60;
    localparam int  LIMIT     = 2000000;

    typedef struct {
        t_verdict             verdict;
        logic [IDX_W-1:0]     idx;
        logic [RANGE_W-1:0]   range;
        logic                 hit;
    } t_scan_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_op = '0;
    logic [COORD_BITS-1:0] i_point_x = '0;
    logic [COORD_BITS-1:0] i_point_y = '0;
    logic [COORD_BITS-1:0] i_point_z = '0;
    logic                  i_point_ok = 1'b0;
    logic [IDX_W-1:0]      i_read_bin = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [2:0]            o_verdict;
    logic [IDX_W-1:0]      o_bin_index;
    logic [RANGE_W-1:0]    o_bin_range;
    logic                  o_bin_hit;

    // scan model state
    longint             m_angle_low, m_angle_high, m_angle_step;
    longint             m_near_limit, m_height_low, m_height_high;
    logic [RANGE_W-1:0] m_nearest [BIN_COUNT];
    logic               m_filled [BIN_COUNT];

    t_scan_result pending_results[$];
    int           errors = 0;
    int           hold_left = 0;
    bit           no_idle = 1'b0;
    longint       cycles = 0;
    int           last_bin = 0;

    point_to_scan_min_range_binning_core uut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // count down a receiver hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint atan_table(input int i);
        longint tab [CORDIC_N] = '{131072, 77376, 40884, 20753, 10416, 5213, 2607,
                                   1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};
        return tab[i];
    endfunction

    // vectoring CORDIC, result in signed 16-bit binary angle units
    function automatic longint planar_angle(input longint x, input longint y);
        longint acc, t, dx, dy, a;
        logic signed [15:0] w;
        if (x == 0 && y == 0) return 0;
        acc = 0;
        x = x * (64'sd1 <<< SCALE_SH);
        y = y * (64'sd1 <<< SCALE_SH);
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; acc = 262144;
            end else begin
                t = x; x = -y; y = t; acc = -262144;
            end
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; acc += atan_table(i);
            end else begin
                x -= dx; y += dy; acc -= atan_table(i);
            end
        end
        a = ((acc + 8 + 1048576) >>> 4) - 65536;
        w = a[15:0];
        return longint'(w);
    endfunction

    function automatic t_scan_result scan_predict(input t_op op,
            input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
            input logic [COORD_BITS-1:0] pz, input logic ok,
            input logic [IDX_W-1:0] rb);
        t_scan_result res;
        longint x, y, z, ang, stp, b;
        longint unsigned r;
        res = '{V_ACCEPT, '0, '0, 1'b0};
        case (op)
            OP_CLEAR: begin
                foreach (m_filled[i]) m_filled[i] = 1'b0;
            end
            OP_ADD: begin
                x = longint'($signed(px));
                y = longint'($signed(py));
                z = longint'($signed(pz));
                r = int_sqrt(x * x + y * y);
                if (r > 64'hFFFFF) r = 64'hFFFFF;
                if (!ok) res.verdict = V_INVALID;
                else if (z > m_height_high || z < m_height_low) res.verdict = V_HEIGHT;
                else if (longint'(r) < m_near_limit) res.verdict = V_NEAR;
                else begin
                    ang = planar_angle(x, y);
                    if (ang < m_angle_low || ang > m_angle_high) res.verdict = V_ANGLE;
                    else begin
                        stp = (m_angle_step != 0) ? m_angle_step : 1;
                        b = (ang - m_angle_low) / stp;
                        if (b > BIN_COUNT - 1) b = BIN_COUNT - 1;
                        if (!m_filled[b] || r < m_nearest[b]) begin
                            m_nearest[b] = r[RANGE_W-1:0];
                            m_filled[b] = 1'b1;
                        end
                        res.idx = b[IDX_W-1:0];
                        res.range = m_nearest[b];
                        res.hit = 1'b1;
                    end
                end
            end
            OP_READ: begin
                res.idx = rb;
                if (m_filled[rb]) begin
                    res.range = m_nearest[rb];
                    res.hit = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int pick_gap();
        int p;
        if (no_idle) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // result side: random stalls, forced hold-off, in-order check
    always @(posedge i_clk) begin
        t_scan_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word verdict=%0d", $time, o_verdict);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_verdict !== exp_r.verdict) begin
                    $display("%0t: verdict exp %0d got %0d", $time, exp_r.verdict, o_verdict);
                    errors++;
                end
                if (o_bin_index !== exp_r.idx) begin
                    $display("%0t: bin_index exp %0d got %0d", $time, exp_r.idx, o_bin_index);
                    errors++;
                end
                if (o_bin_range !== exp_r.range) begin
                    $display("%0t: bin_range exp %0d got %0d", $time, exp_r.range, o_bin_range);
                    errors++;
                end
                if (o_bin_hit !== exp_r.hit) begin
                    $display("%0t: bin_hit exp %0d got %0d", $time, exp_r.hit, o_bin_hit);
                    errors++;
                end
            end
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
        end else if (no_idle) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) < 70) ||
                           ($urandom_range(0, 99) < 50 && i_out_ready);
        end
    end

    task automatic send_word(input t_op op, input logic [COORD_BITS-1:0] px,
            input logic [COORD_BITS-1:0] py, input logic [COORD_BITS-1:0] pz,
            input logic ok, input logic [IDX_W-1:0] rb);
        int gap;
        t_scan_result r;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_point_x <= px;
        i_point_y <= py;
        i_point_z <= pz;
        i_point_ok <= ok;
        i_read_bin <= rb;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = scan_predict(op, px, py, pz, ok, rb);
        if (r.hit) last_bin = r.idx;
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input longint value);
        logic [CFG_W-1:0] d;
        d = value[CFG_W-1:0];
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        case (idx)
            CFG_ANGLE_LOW:   m_angle_low   = longint'($signed(d[15:0]));
            CFG_ANGLE_HIGH:  m_angle_high  = longint'($signed(d[15:0]));
            CFG_ANGLE_STEP:  m_angle_step  = longint'(d[15:0]);
            CFG_NEAR_LIMIT:  m_near_limit  = longint'(d);
            CFG_HEIGHT_LOW:  m_height_low  = longint'($signed(d));
            CFG_HEIGHT_HIGH: m_height_high = longint'($signed(d));
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [COORD_BITS-1:0] rand_coord();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return COORD_BITS'($urandom_range(0, 4000) - 2000);
        if (p < 75) return COORD_BITS'($urandom_range(0, 100000) - 50000);
        return COORD_BITS'($urandom);
    endfunction

    task automatic send_random(input int n);
        int p;
        logic [IDX_W-1:0] rb;
        for (int k = 0; k < n; k++) begin
            p = $urandom_range(0, 199);
            rb = ($urandom_range(0, 1) != 0) ? IDX_W'(last_bin) : IDX_W'($urandom);
            if (p < 1)
                send_word(OP_CLEAR, rand_coord(), rand_coord(), rand_coord(), 1'b1, rb);
            else if (p < 3)
                send_word(OP_UNUSED, rand_coord(), rand_coord(), rand_coord(),
                          1'($urandom), rb);
            else if (p < 45)
                send_word(OP_READ, rand_coord(), rand_coord(), rand_coord(),
                          1'($urandom), rb);
            else
                send_word(OP_ADD, rand_coord(), rand_coord(), rand_coord(),
                          ($urandom_range(0, 19) != 0), rb);
        end
    endtask

    task automatic test_directed();
        send_word(OP_CLEAR, '0, '0, '0, 1'b0, '0);
        send_word(OP_READ, '0, '0, '0, 1'b0, 10'd0);
        send_word(OP_READ, '0, '0, '0, 1'b0, 10'd1023);
        send_word(OP_ADD, 20'd1000, 20'd0, 20'd0, 1'b0, '0);        // invalid
        send_word(OP_ADD, 20'd1000, 20'd0, 20'h80000, 1'b1, '0);    // lowest height
        send_word(OP_ADD, 20'd1000, 20'd0, 20'h7FFFF, 1'b1, '0);    // highest height
        send_word(OP_ADD, 20'd100, 20'd100, 20'd0, 1'b1, '0);       // too near
        send_word(OP_ADD, 20'h80000, 20'h80000, 20'd5, 1'b1, '0);   // largest range, both coordinates most negative
        send_word(OP_ADD, 20'h7FFFF, 20'h7FFFF, 20'd5, 1'b1, '0);
        send_word(OP_ADD, 20'h80000, 20'd0, 20'd5, 1'b1, '0);       // direction pi
        send_word(OP_ADD, 20'h7FFFF, 20'd0, 20'd5, 1'b1, '0);
        send_word(OP_ADD, 20'd0, 20'h7FFFF, 20'd5, 1'b1, '0);
        send_word(OP_ADD, 20'd0, 20'h80000, 20'd5, 1'b1, '0);
        send_word(OP_ADD, 20'd800, 20'd0, 20'd5, 1'b1, '0);         // nearer, same bin
        send_word(OP_ADD, 20'd900, 20'd0, 20'd5, 1'b1, '0);         // farther, bin keeps
        send_word(OP_READ, '0, '0, '0, 1'b0, IDX_W'(last_bin));
        send_word(OP_UNUSED, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b1, 10'h3FF);
        send_word(OP_READ, '0, '0, '0, 1'b1, IDX_W'(last_bin));
        send_word(OP_CLEAR, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b1, 10'h3FF);
        send_word(OP_READ, '0, '0, '0, 1'b0, IDX_W'(last_bin));
        cfg_write(CFG_NEAR_LIMIT, 0);
        send_word(OP_ADD, '0, '0, '0, 1'b1, '0);                    // origin, angle zero
        send_word(OP_READ, '0, '0, '0, 1'b0, IDX_W'(last_bin));
    endtask

    task automatic test_window_settings();
        // narrow step: bins run past the end and clamp
        cfg_write(CFG_ANGLE_STEP, 1);
        send_random(120);
        cfg_write(CFG_ANGLE_STEP, 0);
        send_random(60);
        cfg_write(CFG_ANGLE_STEP, 65535);
        cfg_write(CFG_ANGLE_LOW, -8192);
        cfg_write(CFG_ANGLE_HIGH, 8192);
        send_random(80);
        cfg_write(CFG_ANGLE_STEP, 17);
        send_random(100);
        // empty window
        cfg_write(CFG_ANGLE_LOW, 100);
        cfg_write(CFG_ANGLE_HIGH, 99);
        send_random(40);
        cfg_write(CFG_ANGLE_LOW, -32768);
        cfg_write(CFG_ANGLE_HIGH, 32767);
        cfg_write(CFG_ANGLE_STEP, 64);
    endtask

    task automatic test_limit_settings();
        cfg_write(CFG_NEAR_LIMIT, 1048575);
        send_random(40);
        cfg_write(CFG_NEAR_LIMIT, 1500);
        cfg_write(CFG_HEIGHT_LOW, -1000);
        cfg_write(CFG_HEIGHT_HIGH, 1000);
        send_random(100);
        cfg_write(CFG_HEIGHT_LOW, 524287);
        cfg_write(CFG_HEIGHT_HIGH, -524288);
        send_random(30);
        cfg_write(CFG_HEIGHT_LOW, -524288);
        cfg_write(CFG_HEIGHT_HIGH, 524287);
        cfg_write(CFG_NEAR_LIMIT, 450);
        cfg_write(CFG_ANGLE_STEP, 91);
    endtask

    task automatic test_stalls();
        // receiver holds off while words keep coming
        drain_results();
        hold_left <= 400;
        send_random(20);
        // sender waits until everything is back
        drain_results();
        send_random(20);
        no_idle = 1'b1;
        send_random(80);
        no_idle = 1'b0;
        send_random(160);
    endtask

    initial begin
        m_angle_low = -32768;
        m_angle_high = 32767;
        m_angle_step = 91;
        m_near_limit = 450;
        m_height_low = -524288;
        m_height_high = 524287;
        foreach (m_filled[i]) m_filled[i] = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_window_settings();
        test_limit_settings();
        test_stalls();
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
